// ----- rtl/mesh_rectangle_overlap_merge_defines.svh -----
// ----------------------------------------------------------------------------
// mesh_rectangle_overlap_merge_defines
// Assertion macros shared by the mesh rectangle overlap merge RTL.
// ----------------------------------------------------------------------------
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef MESH_RECTANGLE_OVERLAP_MERGE_DEFINES_SVH
`define MESH_RECTANGLE_OVERLAP_MERGE_DEFINES_SVH

// Same-cycle implication.
`define MROM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrom: same-cycle check failed");

// Next-cycle implication.
`define MROM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrom: next-cycle check failed");

`endif

// ----- rtl/mrom_pkg.sv -----
// ----------------------------------------------------------------------------
// mrom_pkg
// Types and constants for the mesh rectangle overlap merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrom_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int OUT_BITS       = 32;
    localparam int NUM_AXES       = 3;

    typedef enum logic [3:0] {
        OUT_NONE            = 4'd0,
        OUT_FIRST_CONTAINS  = 4'd1,
        OUT_SECOND_CONTAINS = 4'd2,
        OUT_MERGED          = 4'd3,
        OUT_SECOND_EXTENDED = 4'd4,
        OUT_FIRST_EXTENDED  = 4'd5,
        OUT_ONE_NEW         = 4'd6,
        OUT_TWO_NEW         = 4'd7,
        OUT_NO_ACTION       = 4'd8,
        OUT_INVALID         = 4'd9
    } t_outcome;

    typedef enum logic [1:0] {
        ROLE_NONE   = 2'd0,
        ROLE_FIRST  = 2'd1,
        ROLE_SECOND = 2'd2,
        ROLE_NEW    = 2'd3
    } t_role;

    typedef struct packed {
        logic [NUM_AXES-1:0][OUT_BITS-1:0] start;
        logic [NUM_AXES-1:0][OUT_BITS-1:0] stop;
    } t_rect_out;

    // Classification of one rectangle pair; rect1 is used only for two new rectangles.
    typedef struct packed {
        t_outcome  outcome;
        t_role     role;
        t_rect_out rect0;
        t_rect_out rect1;
    } t_class_res;

    // Axis following the given one, cyclic over u, v, w.
    function automatic logic [1:0] next_axis(input logic [1:0] ax);
        logic [1:0] r;
        r = (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mrom_if.sv -----
// ----------------------------------------------------------------------------
// mrom_if
// Valid/ready channels for rectangle pairs in and classified rectangles out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrom_pair_if #(
    parameter int COORD_BITS = mrom_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] first_start_u;
    logic [COORD_BITS-1:0] first_start_v;
    logic [COORD_BITS-1:0] first_start_w;
    logic [COORD_BITS-1:0] first_stop_u;
    logic [COORD_BITS-1:0] first_stop_v;
    logic [COORD_BITS-1:0] first_stop_w;
    logic [COORD_BITS-1:0] second_start_u;
    logic [COORD_BITS-1:0] second_start_v;
    logic [COORD_BITS-1:0] second_start_w;
    logic [COORD_BITS-1:0] second_stop_u;
    logic [COORD_BITS-1:0] second_stop_v;
    logic [COORD_BITS-1:0] second_stop_w;

    modport source (
        output valid,
        output first_start_u, first_start_v, first_start_w,
        output first_stop_u, first_stop_v, first_stop_w,
        output second_start_u, second_start_v, second_start_w,
        output second_stop_u, second_stop_v, second_stop_w,
        input  ready
    );

    modport sink (
        input  valid,
        input  first_start_u, first_start_v, first_start_w,
        input  first_stop_u, first_stop_v, first_stop_w,
        input  second_start_u, second_start_v, second_start_w,
        input  second_stop_u, second_stop_v, second_stop_w,
        output ready
    );
endinterface

interface mrom_result_if;
    logic                            valid;
    logic                            ready;
    logic [3:0]                      outcome;
    logic [1:0]                      rect_role;
    logic [mrom_pkg::OUT_BITS-1:0]   rect_start_u;
    logic [mrom_pkg::OUT_BITS-1:0]   rect_start_v;
    logic [mrom_pkg::OUT_BITS-1:0]   rect_start_w;
    logic [mrom_pkg::OUT_BITS-1:0]   rect_stop_u;
    logic [mrom_pkg::OUT_BITS-1:0]   rect_stop_v;
    logic [mrom_pkg::OUT_BITS-1:0]   rect_stop_w;
    logic                            last_result;

    modport source (
        output valid, outcome, rect_role,
        output rect_start_u, rect_start_v, rect_start_w,
        output rect_stop_u, rect_stop_v, rect_stop_w,
        output last_result,
        input  ready
    );

    modport sink (
        input  valid, outcome, rect_role,
        input  rect_start_u, rect_start_v, rect_start_w,
        input  rect_stop_u, rect_stop_v, rect_stop_w,
        input  last_result,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/mrom_classify.sv -----
// ----------------------------------------------------------------------------
// mrom_classify
// Combinational classification of one rectangle pair and the rectangles
// it produces.
// ----------------------------------------------------------------------------
`default_nettype none

module mrom_classify #(
    parameter int COORD_BITS = mrom_pkg::COORD_BITS_DEF
) (
    input  wire logic [2:0][COORD_BITS-1:0] i_fs,
    input  wire logic [2:0][COORD_BITS-1:0] i_fe,
    input  wire logic [2:0][COORD_BITS-1:0] i_ss,
    input  wire logic [2:0][COORD_BITS-1:0] i_se,
    output mrom_pkg::t_class_res            o_res
);

    localparam int OB = mrom_pkg::OUT_BITS;

    logic [1:0]                  c1, c2, p, q, a, b;
    logic                        has1, has2, ovl, cont_f, cont_s, done, touch, crossed;
    logic [2:0][COORD_BITS-1:0]  ns0, ne0, ns1, ne1;

    always_comb begin
        c1   = 2'd0;
        c2   = 2'd0;
        has1 = 1'b0;
        has2 = 1'b0;
        // The constant direction is the last axis on which start equals stop.
        for (int i = 0; i < 3; i++) begin
            if (i_fs[i] == i_fe[i]) begin
                c1   = 2'(i);
                has1 = 1'b1;
            end
            if (i_ss[i] == i_se[i]) begin
                c2   = 2'(i);
                has2 = 1'b1;
            end
        end
        p = mrom_pkg::next_axis(c1);
        q = mrom_pkg::next_axis(p);

        ovl = has2 && (c1 == c2) && (i_fs[c1] == i_ss[c1])
            && (i_fs[p] <= i_se[p]) && (i_fe[p] >= i_ss[p])
            && (i_fs[q] <= i_se[q]) && (i_fe[q] >= i_ss[q]);
        cont_f = (i_fs[p] <= i_ss[p]) && (i_fe[p] >= i_se[p])
              && (i_fs[q] <= i_ss[q]) && (i_fe[q] >= i_se[q]);
        cont_s = (i_ss[p] <= i_fs[p]) && (i_se[p] >= i_fe[p])
              && (i_ss[q] <= i_fs[q]) && (i_se[q] >= i_fe[q]);

        o_res         = '0;
        o_res.outcome = mrom_pkg::OUT_NONE;
        o_res.role    = mrom_pkg::ROLE_NONE;
        ns0  = i_ss;
        ne0  = i_se;
        ns1  = i_ss;
        ne1  = i_se;
        done = 1'b0;
        a    = p;
        b    = q;
        touch   = 1'b0;
        crossed = 1'b0;

        if (!has1) begin
            o_res.outcome = mrom_pkg::OUT_INVALID;
        end else if (!ovl) begin
            o_res.outcome = mrom_pkg::OUT_NONE;
        end else if (cont_f) begin
            o_res.outcome = mrom_pkg::OUT_FIRST_CONTAINS;
        end else if (cont_s) begin
            o_res.outcome = mrom_pkg::OUT_SECOND_CONTAINS;
        end else begin
            // Try both variable axes in turn as the axis of extension.
            for (int it = 0; it < 2; it++) begin
                if (!done) begin
                    a = (it == 0) ? p : q;
                    b = (it == 0) ? q : p;
                    touch = (i_fe[a] == i_ss[a]) || (i_fs[a] == i_se[a]);
                    if (touch && (i_fs[b] == i_ss[b]) && (i_fe[b] == i_se[b])) begin
                        ns0    = i_ss;
                        ne0    = i_se;
                        ns0[a] = (i_fs[a] < i_ss[a]) ? i_fs[a] : i_ss[a];
                        ne0[a] = (i_fe[a] > i_se[a]) ? i_fe[a] : i_se[a];
                        o_res.outcome = mrom_pkg::OUT_MERGED;
                        o_res.role    = mrom_pkg::ROLE_SECOND;
                        done = 1'b1;
                    end else if (touch &&
                                 (((i_fs[b] < i_ss[b]) && (i_fe[b] < i_se[b])) ||
                                  ((i_fs[b] > i_ss[b]) && (i_fe[b] > i_se[b])))) begin
                        ns0[c1] = i_fs[c1];
                        ne0[c1] = i_fe[c1];
                        ns0[a]  = (i_fs[a] < i_ss[a]) ? i_fs[a] : i_ss[a];
                        ne0[a]  = (i_fe[a] > i_se[a]) ? i_fe[a] : i_se[a];
                        ns0[b]  = (i_fs[b] > i_ss[b]) ? i_fs[b] : i_ss[b];
                        ne0[b]  = (i_fe[b] < i_se[b]) ? i_fe[b] : i_se[b];
                        o_res.outcome = mrom_pkg::OUT_ONE_NEW;
                        o_res.role    = mrom_pkg::ROLE_NEW;
                        done = 1'b1;
                    end else if ((i_fs[b] <= i_ss[b]) && (i_fe[b] >= i_se[b]) &&
                                 ((i_fs[a] < i_ss[a]) || (i_fe[a] > i_se[a]))) begin
                        ns0 = i_ss;
                        ne0 = i_se;
                        if (i_fs[a] < i_ss[a]) begin
                            ns0[a] = i_fs[a];
                        end else begin
                            ne0[a] = i_fe[a];
                        end
                        o_res.outcome = mrom_pkg::OUT_SECOND_EXTENDED;
                        o_res.role    = mrom_pkg::ROLE_SECOND;
                        done = 1'b1;
                    end else if ((i_ss[b] <= i_fs[b]) && (i_se[b] >= i_fe[b]) &&
                                 ((i_ss[a] < i_fs[a]) || (i_se[a] > i_fe[a]))) begin
                        ns0 = i_fs;
                        ne0 = i_fe;
                        if (i_ss[a] < i_fs[a]) begin
                            ns0[a] = i_ss[a];
                        end else begin
                            ne0[a] = i_se[a];
                        end
                        o_res.outcome = mrom_pkg::OUT_FIRST_EXTENDED;
                        o_res.role    = mrom_pkg::ROLE_FIRST;
                        done = 1'b1;
                    end
                end
            end

            if (!done) begin
                crossed =
                    ((i_se[p] >= i_fe[p]) && (i_ss[p] <= i_fs[p]) &&
                     (i_fe[q] >= i_se[q]) && (i_fs[q] <= i_ss[q])) ||
                    ((i_fe[p] >= i_se[p]) && (i_fs[p] <= i_ss[p]) &&
                     (i_se[q] >= i_fe[q]) && (i_ss[q] <= i_fs[q]));
                if (!crossed && (i_fs[p] < i_se[p]) && (i_fe[p] > i_ss[p]) &&
                    (i_fs[q] < i_se[q]) && (i_fe[q] > i_ss[q])) begin
                    ns0[c1] = i_fs[c1];
                    ne0[c1] = i_fe[c1];
                    ns0[p]  = (i_fs[p] < i_ss[p]) ? i_fs[p] : i_ss[p];
                    ne0[p]  = (i_fe[p] > i_se[p]) ? i_fe[p] : i_se[p];
                    ns0[q]  = (i_fs[q] > i_ss[q]) ? i_fs[q] : i_ss[q];
                    ne0[q]  = (i_fe[q] < i_se[q]) ? i_fe[q] : i_se[q];
                    ns1[c1] = i_fs[c1];
                    ne1[c1] = i_fe[c1];
                    ns1[p]  = (i_fs[p] > i_ss[p]) ? i_fs[p] : i_ss[p];
                    ne1[p]  = (i_fe[p] < i_se[p]) ? i_fe[p] : i_se[p];
                    ns1[q]  = (i_fs[q] < i_ss[q]) ? i_fs[q] : i_ss[q];
                    ne1[q]  = (i_fe[q] > i_se[q]) ? i_fe[q] : i_se[q];
                    o_res.outcome = mrom_pkg::OUT_TWO_NEW;
                    o_res.role    = mrom_pkg::ROLE_NEW;
                    for (int k = 0; k < 3; k++) begin
                        o_res.rect1.start[k] = OB'(ns1[k]);
                        o_res.rect1.stop[k]  = OB'(ne1[k]);
                    end
                end else begin
                    o_res.outcome = mrom_pkg::OUT_NO_ACTION;
                end
            end

            if (o_res.role != mrom_pkg::ROLE_NONE) begin
                for (int k = 0; k < 3; k++) begin
                    o_res.rect0.start[k] = OB'(ns0[k]);
                    o_res.rect0.stop[k]  = OB'(ne0[k]);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mesh_rectangle_overlap_merge.sv -----
// ----------------------------------------------------------------------------
// mesh_rectangle_overlap_merge
// Classifies a pair of mesh rectangles and emits the rectangles that the
// overlap changes or creates.
// ----------------------------------------------------------------------------
//  Channel    Port       Dir  Payload
//  pairs      i_pair     in   first/second start and stop on u, v, w
//  results    o_result   out  outcome, role, rectangle, last flag
//
//  A pair is registered on entry, classified combinationally from the input
//  register and its first result is held in the output register.
//  One pair is taken per cycle while the output register is free; a pair giving
//  two new rectangles holds the output register for two beats.
//  Synchronous active-low reset clears the valid flags and the beat flag only.
//  A stalled output holds its result; the input register still takes a pair only while it is empty.
`default_nettype none

`include "mesh_rectangle_overlap_merge_defines.svh"

module mesh_rectangle_overlap_merge #(
    parameter int COORD_BITS = mrom_pkg::COORD_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mrom_pair_if.sink     i_pair,
    mrom_result_if.source o_result
);

    logic                        r_s1_valid;
    logic [2:0][COORD_BITS-1:0]  r_fs, r_fe, r_ss, r_se;
    mrom_pkg::t_class_res        w_class;

    logic                        r_out_valid;
    logic                        r_beat;
    mrom_pkg::t_class_res        r_res;
    logic                        w_last;
    logic                        w_out_free;
    mrom_pkg::t_rect_out         w_rect;

    // The output register can reload once it is empty or its last beat leaves.
    assign w_last     = (r_res.outcome != mrom_pkg::OUT_TWO_NEW) || r_beat;
    assign w_out_free = !r_out_valid || (o_result.ready && w_last);
    assign i_pair.ready = !r_s1_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pair.ready) begin
            r_s1_valid <= i_pair.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pair.valid && i_pair.ready) begin
            r_fs <= {i_pair.first_start_w, i_pair.first_start_v, i_pair.first_start_u};
            r_fe <= {i_pair.first_stop_w, i_pair.first_stop_v, i_pair.first_stop_u};
            r_ss <= {i_pair.second_start_w, i_pair.second_start_v, i_pair.second_start_u};
            r_se <= {i_pair.second_stop_w, i_pair.second_stop_v, i_pair.second_stop_u};
        end
    end

    mrom_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .i_fs  (r_fs),
        .i_fe  (r_fe),
        .i_ss  (r_ss),
        .i_se  (r_se),
        .o_res (w_class)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_beat      <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
            r_beat      <= 1'b0;
        end else if (o_result.ready) begin
            r_beat <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_res <= w_class;
        end
    end

    assign w_rect = r_beat ? r_res.rect1 : r_res.rect0;

    assign o_result.valid        = r_out_valid;
    assign o_result.outcome      = r_res.outcome;
    assign o_result.rect_role    = r_res.role;
    assign o_result.rect_start_u = w_rect.start[0];
    assign o_result.rect_start_v = w_rect.start[1];
    assign o_result.rect_start_w = w_rect.start[2];
    assign o_result.rect_stop_u  = w_rect.stop[0];
    assign o_result.rect_stop_v  = w_rect.stop[1];
    assign o_result.rect_stop_w  = w_rect.stop[2];
    assign o_result.last_result  = w_last;

    // The second beat exists only for a pair that gives two new rectangles.
    `MROM_ASSERT_IMP(a_second_beat_two_new, i_clk, i_rst_n, r_out_valid && r_beat,
        r_res.outcome == mrom_pkg::OUT_TWO_NEW)
    // A transaction that is not the last is followed by the second beat.
    `MROM_ASSERT_NXT(a_beat_follows, i_clk, i_rst_n,
        o_result.valid && o_result.ready && !o_result.last_result,
        o_result.valid && r_beat)
    // Results without a rectangle carry an all-zero rectangle.
    `MROM_ASSERT_IMP(a_no_rect_zero, i_clk, i_rst_n,
        r_out_valid && (r_res.role == mrom_pkg::ROLE_NONE), r_res.rect0 == '0)

endmodule

`default_nettype wire

// ----- verif/mesh_rectangle_overlap_merge_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_rectangle_overlap_merge_tb
// Drives rectangle pairs into the overlap classifier and checks every result
// transaction against an in-bench prediction of outcome, role, rectangle and
// last flag. A directed set covers each outcome and the extreme coordinates,
// then structured random pairs with random gaps on both channels follow,
// including one long hold-off on the result channel.
// ----------------------------------------------------------------------------

module mesh_rectangle_overlap_merge_tb;

    localparam int CLK_HALF     = 10;
    localparam int RAND_PAIRS   = 1500;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AFTER   = 300;
    localparam int CALM_FROM    = 1500;
    localparam int CALM_TO      = 2000;
    localparam int IDLE_PERCENT = 18;

    typedef logic [31:0] t_coord;

    typedef struct packed {
        logic [2:0][31:0] s;
        logic [2:0][31:0] e;
    } t_rect;

    typedef struct packed {
        t_rect f;
        t_rect sc;
    } t_pair;

    typedef struct packed {
        mrom_pkg::t_outcome outcome;
        mrom_pkg::t_role    role;
        logic [2:0][31:0]   s;
        logic [2:0][31:0]   e;
        logic               last;
    } t_rect_result;

    logic i_clk;
    logic i_rst_n;

    mrom_pair_if #(.COORD_BITS(32)) pair_ch ();
    mrom_result_if                  result_ch ();

    mesh_rectangle_overlap_merge #(.COORD_BITS(32)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pair   (pair_ch),
        .o_result (result_ch)
    );

    t_pair        pending_pairs[$];
    t_rect_result expected_rects[$];

    int   cyc = 0;
    int   pairs_in = 0;
    int   total_pairs = 0;
    int   quiet_cycles = 0;
    int   mismatches = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    logic taken = 1'b0;
    logic calm;

    assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic t_coord lo_of(t_coord x, t_coord y);
        return (x < y) ? x : y;
    endfunction

    function automatic t_coord hi_of(t_coord x, t_coord y);
        return (x > y) ? x : y;
    endfunction

    // The flat axis is the last one on which start and stop agree.
    function automatic int flat_axis(logic [2:0][31:0] s, logic [2:0][31:0] e);
        int c;
        c = -1;
        for (int i = 0; i < 3; i++) begin
            if (s[i] == e[i]) c = i;
        end
        return c;
    endfunction

    function automatic void push_rect(mrom_pkg::t_outcome o, mrom_pkg::t_role r,
                                      logic [2:0][31:0] s, logic [2:0][31:0] e,
                                      logic last);
        t_rect_result x;
        x.outcome = o;
        x.role    = r;
        x.s       = s;
        x.e       = e;
        x.last    = last;
        expected_rects = {expected_rects, x};
    endfunction

    function automatic void classify_pair(t_pair pr);
        logic [2:0][31:0] fs, fe, ss, se, ns, ne;
        int  c1, c2, p, q, a, b;
        bit  crossed;
        fs = pr.f.s;
        fe = pr.f.e;
        ss = pr.sc.s;
        se = pr.sc.e;
        c1 = flat_axis(fs, fe);
        if (c1 < 0) begin
            push_rect(mrom_pkg::OUT_INVALID, mrom_pkg::ROLE_NONE, '0, '0, 1'b1);
            return;
        end
        c2 = flat_axis(ss, se);
        p  = (c1 + 1) % 3;
        q  = (c1 + 2) % 3;

        if (c2 != c1 || fs[c1] != ss[c1] || fs[p] > se[p] || fe[p] < ss[p] ||
            fs[q] > se[q] || fe[q] < ss[q]) begin
            push_rect(mrom_pkg::OUT_NONE, mrom_pkg::ROLE_NONE, '0, '0, 1'b1);
            return;
        end
        if (fs[p] <= ss[p] && fe[p] >= se[p] && fs[q] <= ss[q] && fe[q] >= se[q]) begin
            push_rect(mrom_pkg::OUT_FIRST_CONTAINS, mrom_pkg::ROLE_NONE, '0, '0, 1'b1);
            return;
        end
        if (ss[p] <= fs[p] && se[p] >= fe[p] && ss[q] <= fs[q] && se[q] >= fe[q]) begin
            push_rect(mrom_pkg::OUT_SECOND_CONTAINS, mrom_pkg::ROLE_NONE, '0, '0, 1'b1);
            return;
        end

        // Try each variable axis as the one along which the pair joins.
        for (int i = 0; i < 2; i++) begin
            a = (i == 0) ? p : q;
            b = (i == 0) ? q : p;
            if (fe[a] == ss[a] || fs[a] == se[a]) begin
                if (fs[b] == ss[b] && fe[b] == se[b]) begin
                    ns    = ss;
                    ne    = se;
                    ns[a] = lo_of(fs[a], ss[a]);
                    ne[a] = hi_of(fe[a], se[a]);
                    push_rect(mrom_pkg::OUT_MERGED, mrom_pkg::ROLE_SECOND, ns, ne, 1'b1);
                    return;
                end else if ((fs[b] < ss[b] && fe[b] < se[b]) ||
                             (fs[b] > ss[b] && fe[b] > se[b])) begin
                    ns     = '0;
                    ne     = '0;
                    ns[c1] = fs[c1];
                    ne[c1] = fe[c1];
                    ns[a]  = lo_of(ss[a], fs[a]);
                    ne[a]  = hi_of(se[a], fe[a]);
                    ns[b]  = hi_of(ss[b], fs[b]);
                    ne[b]  = lo_of(se[b], fe[b]);
                    push_rect(mrom_pkg::OUT_ONE_NEW, mrom_pkg::ROLE_NEW, ns, ne, 1'b1);
                    return;
                end
            end
            if (fs[b] <= ss[b] && fe[b] >= se[b] && (fs[a] < ss[a] || fe[a] > se[a])) begin
                ns = ss;
                ne = se;
                if (fs[a] < ss[a]) ns[a] = fs[a];
                else ne[a] = fe[a];
                push_rect(mrom_pkg::OUT_SECOND_EXTENDED, mrom_pkg::ROLE_SECOND, ns, ne, 1'b1);
                return;
            end
            if (ss[b] <= fs[b] && se[b] >= fe[b] && (ss[a] < fs[a] || se[a] > fe[a])) begin
                ns = fs;
                ne = fe;
                if (ss[a] < fs[a]) ns[a] = ss[a];
                else ne[a] = se[a];
                push_rect(mrom_pkg::OUT_FIRST_EXTENDED, mrom_pkg::ROLE_FIRST, ns, ne, 1'b1);
                return;
            end
        end

        // A cross-shaped overlap needs nothing; a corner overlap gives two rectangles.
        crossed = (se[p] >= fe[p] && ss[p] <= fs[p] && fe[q] >= se[q] && fs[q] <= ss[q]) ||
                  (fe[p] >= se[p] && fs[p] <= ss[p] && se[q] >= fe[q] && ss[q] <= fs[q]);
        if (!crossed && fs[p] < se[p] && fe[p] > ss[p] && fs[q] < se[q] && fe[q] > ss[q]) begin
            ns     = '0;
            ne     = '0;
            ns[c1] = fs[c1];
            ne[c1] = fe[c1];
            ns[p]  = lo_of(ss[p], fs[p]);
            ne[p]  = hi_of(se[p], fe[p]);
            ns[q]  = hi_of(ss[q], fs[q]);
            ne[q]  = lo_of(se[q], fe[q]);
            push_rect(mrom_pkg::OUT_TWO_NEW, mrom_pkg::ROLE_NEW, ns, ne, 1'b0);
            ns[p]  = hi_of(ss[p], fs[p]);
            ne[p]  = lo_of(se[p], fe[p]);
            ns[q]  = lo_of(ss[q], fs[q]);
            ne[q]  = hi_of(se[q], fe[q]);
            push_rect(mrom_pkg::OUT_TWO_NEW, mrom_pkg::ROLE_NEW, ns, ne, 1'b1);
            return;
        end
        push_rect(mrom_pkg::OUT_NO_ACTION, mrom_pkg::ROLE_NONE, '0, '0, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_rect make_rect(int c, t_coord lvl, t_coord p0, t_coord p1,
                                        t_coord q0, t_coord q1);
        t_rect r;
        int    p, q;
        p      = (c + 1) % 3;
        q      = (c + 2) % 3;
        r.s[c] = lvl;
        r.e[c] = lvl;
        r.s[p] = p0;
        r.e[p] = p1;
        r.s[q] = q0;
        r.e[q] = q1;
        return r;
    endfunction

    // Coordinates close to a common base, so that shared edges come up often.
    function automatic t_rect rand_rect(int c, t_coord lvl, t_coord base);
        t_coord x[4];
        t_coord t;
        for (int k = 0; k < 4; k++) x[k] = base + $urandom_range(0, 6);
        if (x[0] > x[1] && $urandom_range(0, 9) != 0) begin
            t    = x[0];
            x[0] = x[1];
            x[1] = t;
        end
        if (x[2] > x[3] && $urandom_range(0, 9) != 0) begin
            t    = x[2];
            x[2] = x[3];
            x[3] = t;
        end
        return make_rect(c, lvl, x[0], x[1], x[2], x[3]);
    endfunction

    function automatic void queue_pair(t_rect a, t_rect b);
        t_pair pr;
        pr.f  = a;
        pr.sc = b;
        pending_pairs = {pending_pairs, pr};
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Pair driver: a new transaction is offered only once the last one is taken.
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin : driver
        t_pair nxt;
        if (!i_rst_n) begin
            pair_ch.valid <= 1'b0;
        end else if (!pair_ch.valid || taken) begin
            if (pending_pairs.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                nxt = pending_pairs.pop_front();
                pair_ch.valid          <= 1'b1;
                pair_ch.first_start_u  <= nxt.f.s[0];
                pair_ch.first_start_v  <= nxt.f.s[1];
                pair_ch.first_start_w  <= nxt.f.s[2];
                pair_ch.first_stop_u   <= nxt.f.e[0];
                pair_ch.first_stop_v   <= nxt.f.e[1];
                pair_ch.first_stop_w   <= nxt.f.e[2];
                pair_ch.second_start_u <= nxt.sc.s[0];
                pair_ch.second_start_v <= nxt.sc.s[1];
                pair_ch.second_start_w <= nxt.sc.s[2];
                pair_ch.second_stop_u  <= nxt.sc.e[0];
                pair_ch.second_stop_v  <= nxt.sc.e[1];
                pair_ch.second_stop_w  <= nxt.sc.e[2];
            end else begin
                pair_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off once the run is under way.
    always @(negedge i_clk) begin : receiver
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else if (!hold_done && pairs_in >= HOLD_AFTER) begin
            result_ch.ready <= 1'b0;
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
        end else begin
            result_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: prediction on each pair transaction, checking on each result.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : monitor
        t_pair        got_pair;
        t_rect_result want;
        bit           moved;
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            taken <= 1'b0;
        end else begin
            moved = 1'b0;
            taken <= pair_ch.valid && pair_ch.ready;
            if (pair_ch.valid && pair_ch.ready) begin
                got_pair.f.s  = {pair_ch.first_start_w, pair_ch.first_start_v,
                                 pair_ch.first_start_u};
                got_pair.f.e  = {pair_ch.first_stop_w, pair_ch.first_stop_v,
                                 pair_ch.first_stop_u};
                got_pair.sc.s = {pair_ch.second_start_w, pair_ch.second_start_v,
                                 pair_ch.second_start_u};
                got_pair.sc.e = {pair_ch.second_stop_w, pair_ch.second_stop_v,
                                 pair_ch.second_stop_u};
                classify_pair(got_pair);
                pairs_in <= pairs_in + 1;
                moved = 1'b1;
            end
            if (result_ch.valid && result_ch.ready) begin
                moved = 1'b1;
                if (expected_rects.size() == 0) begin
                    $error("result transaction with nothing expected: outcome %0d",
                           result_ch.outcome);
                    mismatches++;
                end else begin
                    want = expected_rects.pop_front();
                    check_field("outcome", want.outcome, result_ch.outcome);
                    check_field("rect_role", want.role, result_ch.rect_role);
                    check_field("rect_start_u", want.s[0], result_ch.rect_start_u);
                    check_field("rect_start_v", want.s[1], result_ch.rect_start_v);
                    check_field("rect_start_w", want.s[2], result_ch.rect_start_w);
                    check_field("rect_stop_u", want.e[0], result_ch.rect_stop_u);
                    check_field("rect_stop_v", want.e[1], result_ch.rect_stop_v);
                    check_field("rect_stop_w", want.e[2], result_ch.rect_stop_w);
                    check_field("last_result", want.last, result_ch.last_result);
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial begin : stimulus
        t_rect  ra, rb;
        t_coord lvl1, lvl2, base;
        int     kind, c1, c2;

        pair_ch.valid          = 1'b0;
        pair_ch.first_start_u  = '0;
        pair_ch.first_start_v  = '0;
        pair_ch.first_start_w  = '0;
        pair_ch.first_stop_u   = '0;
        pair_ch.first_stop_v   = '0;
        pair_ch.first_stop_w   = '0;
        pair_ch.second_start_u = '0;
        pair_ch.second_start_v = '0;
        pair_ch.second_start_w = '0;
        pair_ch.second_stop_u  = '0;
        pair_ch.second_stop_v  = '0;
        pair_ch.second_stop_w  = '0;
        result_ch.ready        = 1'b0;
        i_rst_n                = 1'b0;

        // First rectangle with no flat axis is invalid, also at the extremes.
        ra.s = {32'd3, 32'd2, 32'd1};
        ra.e = {32'd6, 32'd5, 32'd4};
        queue_pair(ra, make_rect(2, 32'd3, 0, 10, 0, 10));
        ra.s = '0;
        ra.e = '1;
        rb.s = '1;
        rb.e = '1;
        queue_pair(ra, rb);
        // Second rectangle with no flat axis, then flat axes that differ.
        queue_pair(make_rect(2, 32'h0001_8000, 0, 10, 0, 10), ra);
        queue_pair(make_rect(2, 32'h0001_8000, 0, 10, 0, 10),
                   make_rect(0, 32'h0001_8000, 0, 10, 0, 10));
        // Same axis but another level, and same plane but apart.
        queue_pair(make_rect(2, 32'h0001_8000, 0, 10, 0, 10),
                   make_rect(2, 32'h0001_8001, 0, 10, 0, 10));
        queue_pair(make_rect(2, 32'h0001_8000, 0, 10, 0, 10),
                   make_rect(2, 32'h0001_8000, 20, 30, 0, 10));
        // Containment both ways, with full-range coordinates.
        queue_pair(make_rect(2, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF),
                   make_rect(2, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
        queue_pair(make_rect(2, 32'h0001_8000, 10, 20, 10, 20),
                   make_rect(2, 32'h0001_8000, 0, 100, 0, 100));
        queue_pair(make_rect(2, 32'd0, 0, 0, 0, 0), make_rect(2, 32'd0, 0, 0, 0, 0));
        // Merge along either variable axis.
        queue_pair(make_rect(2, 32'h0001_8000, 0, 10, 0, 10),
                   make_rect(2, 32'h0001_8000, 10, 20, 0, 10));
        queue_pair(make_rect(1, 32'h0001_8000, 0, 10, 0, 10),
                   make_rect(1, 32'h0001_8000, 0, 10, 10, 20));
        queue_pair(make_rect(0, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF),
                   make_rect(0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                             0, 32'hFFFF_FFFF));
        // One new crossing rectangle, staggered either way.
        queue_pair(make_rect(2, 32'h0001_8000, 0, 10, 0, 10),
                   make_rect(2, 32'h0001_8000, 10, 20, 5, 15));
        queue_pair(make_rect(2, 32'h0001_8000, 0, 10, 5, 15),
                   make_rect(2, 32'h0001_8000, 10, 20, 0, 10));
        // Extension of the second, then of the first.
        queue_pair(make_rect(2, 32'h0001_8000, 0, 15, 0, 20),
                   make_rect(2, 32'h0001_8000, 5, 25, 5, 15));
        queue_pair(make_rect(2, 32'h0001_8000, 5, 25, 5, 15),
                   make_rect(2, 32'h0001_8000, 0, 15, 0, 20));
        // Corner overlaps giving two new rectangles.
        queue_pair(make_rect(0, 32'h0001_8000, 0, 10, 0, 10),
                   make_rect(0, 32'h0001_8000, 5, 15, 5, 15));
        queue_pair(make_rect(1, 32'h8000_0000, 0, 32'h8000_0000, 0, 32'h8000_0000),
                   make_rect(1, 32'h8000_0000, 32'h4000_0000, 32'hFFFF_FFFF,
                             32'h4000_0000, 32'hFFFF_FFFF));
        // A cross-shaped overlap needs no action.
        queue_pair(make_rect(2, 32'h0001_8000, 0, 20, 5, 10),
                   make_rect(2, 32'h0001_8000, 5, 10, 0, 20));

        for (int n = 0; n < RAND_PAIRS; n++) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                ra.s = {$urandom, $urandom, $urandom};
                ra.e = {$urandom, $urandom, $urandom};
                rb.s = {$urandom, $urandom, $urandom};
                rb.e = {$urandom, $urandom, $urandom};
            end else begin
                c1   = $urandom_range(0, 2);
                c2   = (kind < 14) ? $urandom_range(0, 2) : c1;
                lvl1 = $urandom;
                lvl2 = (kind >= 14 && kind < 20) ? lvl1 + 1 : lvl1;
                case ($urandom_range(0, 15))
                    0:       base = '0;
                    1:       base = 32'hFFFF_FFF9;
                    default: base = $urandom;
                endcase
                ra = rand_rect(c1, lvl1, base);
                rb = rand_rect(c2, lvl2, base);
            end
            queue_pair(ra, rb);
        end
        total_pairs = pending_pairs.size();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pairs_in < total_pairs) @(posedge i_clk);
        while (expected_rects.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mrom_pkg.sv
rtl/mrom_if.sv
rtl/mrom_classify.sv
rtl/mesh_rectangle_overlap_merge.sv
verif/mesh_rectangle_overlap_merge_tb.sv
